// ----- rtl/core/qss_pkg.sv -----
// Package for the quick search substring matcher.
// Holds the controller state type, the table request struct and fixed widths.
// No dependencies.
`timescale 1ns / 1ps

package qss_pkg;

    localparam int BYTE_W      = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int COUNT_W     = 11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_WIN,
        ST_CMP,
        ST_SHIFT,
        ST_SH_TXT,
        ST_SH_TBL
    } qss_state_t;

    typedef struct packed {
        logic              clr;
        logic              wr;
        logic              rd;
        logic [BYTE_W-1:0] addr;
    } qss_tbl_req_t;

endpackage

// ----- rtl/core/qss_table.sv -----
// Last-occurrence table: 256-entry synchronous memory with per-entry valid bits.
// Depends on qss_pkg; an entry not written since the last clear reads as zero.
`timescale 1ns / 1ps

module qss_table
    import qss_pkg::*;
#(
    parameter int DW = 7
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  qss_tbl_req_t req,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0]          tbl_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [DW-1:0]          rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clr)
        begin
            valid_reg <= '0;
        end
        else if (req.wr)
        begin
            valid_reg[req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            tbl_mem[req.addr] <= wdata;
        end
        if (req.rd)
        begin
            rd_data_reg  <= tbl_mem[req.addr];
            rd_valid_reg <= valid_reg[req.addr];
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- rtl/core/quick_search_substring_match_top.sv -----
// Top level of the quick search substring matcher: byte intake, table build, search.
// Depends on qss_pkg and qss_table; pattern and text stores are local memories.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------
//   input   | in        | start & !busy          | cmd, data_byte, is_last
//   result  | out       | done (one-cycle pulse) | found, match_count, text_overflow
//
// A pattern or text byte is written to its store as it is accepted.
// Closing a pattern (its last byte, or a text byte while open) sweeps it into the table.
// The search visits WIN, CMP per byte compared, SHIFT, SH_TXT and SH_TBL for each window
// (only WIN, CMP and SHIFT on the window that ends at the line end), as the pattern, text
// and table memories give one read per cycle; one more WIN state then gives the result.
// Reset clears lengths, ovf/pend flags and table valid bits at once; no clearing pass.
// The receiver cannot stall: done is high for exactly one cycle per text line.
`timescale 1ns / 1ps

module quick_search_substring_match_top
    import qss_pkg::*;
#(
    parameter int PATTERN_MAX = 64,
    parameter int TEXT_DEPTH  = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic               is_last,
    output logic               done,
    output logic               found,
    output logic [COUNT_W-1:0] match_count,
    output logic               text_overflow
);

    localparam int PLW = $clog2(PATTERN_MAX + 1);
    localparam int TLW = $clog2(TEXT_DEPTH + 1);
    localparam int KW  = $clog2(TEXT_DEPTH + PATTERN_MAX + 2);
    localparam int PAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int TAW = $clog2(TEXT_DEPTH);

    qss_state_t         state_reg, state_next;
    logic [PLW-1:0]     plen_reg, plen_next;
    logic               closed_reg, closed_next;
    logic [TLW-1:0]     tlen_reg, tlen_next;
    logic               ovf_reg, ovf_next;
    logic               pend_reg, pend_next;
    logic [PLW-1:0]     bcnt_reg, bcnt_next;
    logic               brdv_reg, brdv_next;
    logic [PLW-1:0]     bidx_reg, bidx_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [PAW-1:0]     ci_reg, ci_next;
    logic [TAW-1:0]     cj_reg, cj_next;
    logic [COUNT_W-1:0] hits_reg, hits_next;
    logic               done_reg, done_next;
    logic               found_reg, found_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               tovf_reg, tovf_next;

    logic [BYTE_W-1:0]  pat_mem [PATTERN_MAX];
    logic [BYTE_W-1:0]  txt_mem [TEXT_DEPTH];
    logic               pat_we, pat_re, txt_we, txt_re;
    logic [PAW-1:0]     pat_waddr, pat_raddr;
    logic [TAW-1:0]     txt_waddr, txt_raddr;
    logic [BYTE_W-1:0]  pat_q, txt_q;

    qss_tbl_req_t       tbl_req;
    logic [PLW-1:0]     tbl_wdata;
    logic [PLW-1:0]     tbl_rdata;

    logic               accept;
    logic [PLW-1:0]     pbase;

    qss_table #(
        .DW (PLW)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    assign accept = start && (state_reg == ST_IDLE);
    assign pbase  = closed_reg ? '0 : plen_reg;

    always_comb
    begin
        state_next  = state_reg;
        plen_next   = plen_reg;
        closed_next = closed_reg;
        tlen_next   = tlen_reg;
        ovf_next    = ovf_reg;
        pend_next   = pend_reg;
        bcnt_next   = bcnt_reg;
        brdv_next   = brdv_reg;
        bidx_next   = bidx_reg;
        k_next      = k_reg;
        ci_next     = ci_reg;
        cj_next     = cj_reg;
        hits_next   = hits_reg;
        done_next   = 1'b0;
        found_next  = found_reg;
        count_next  = count_reg;
        tovf_next   = tovf_reg;
        pat_we      = 1'b0;
        pat_waddr   = pbase[PAW-1:0];
        pat_re      = 1'b0;
        pat_raddr   = ci_reg;
        txt_we      = 1'b0;
        txt_waddr   = tlen_reg[TAW-1:0];
        txt_re      = 1'b0;
        txt_raddr   = cj_reg;
        tbl_req     = '0;
        tbl_wdata   = bidx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!cmd)
                    begin
                        closed_next = 1'b0;
                        if (pbase < PLW'(PATTERN_MAX))
                        begin
                            pat_we    = 1'b1;
                            plen_next = pbase + 1'b1;
                        end
                        else
                        begin
                            plen_next = pbase;
                        end
                        if (is_last)
                        begin
                            tbl_req.clr = 1'b1;
                            bcnt_next   = '0;
                            brdv_next   = 1'b0;
                            pend_next   = 1'b0;
                            state_next  = ST_BUILD;
                        end
                    end
                    else
                    begin
                        if (tlen_reg < TLW'(TEXT_DEPTH))
                        begin
                            txt_we    = 1'b1;
                            tlen_next = tlen_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (!closed_reg)
                        begin
                            tbl_req.clr = 1'b1;
                            bcnt_next   = '0;
                            brdv_next   = 1'b0;
                            pend_next   = is_last;
                            state_next  = ST_BUILD;
                        end
                        else if (is_last)
                        begin
                            k_next     = KW'(plen_reg);
                            hits_next  = '0;
                            state_next = ST_WIN;
                        end
                    end
                end
            end

            ST_BUILD:
            begin
                if (brdv_reg)
                begin
                    tbl_req.wr   = 1'b1;
                    tbl_req.addr = pat_q;
                end
                brdv_next = (bcnt_reg < plen_reg);
                if (bcnt_reg < plen_reg)
                begin
                    pat_re    = 1'b1;
                    pat_raddr = bcnt_reg[PAW-1:0];
                    bcnt_next = bcnt_reg + 1'b1;
                    bidx_next = bcnt_reg + 1'b1;
                end
                else if (!brdv_reg)
                begin
                    closed_next = 1'b1;
                    pend_next   = 1'b0;
                    if (pend_reg)
                    begin
                        k_next     = KW'(plen_reg);
                        hits_next  = '0;
                        state_next = ST_WIN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_WIN:
            begin
                if (k_reg > KW'(tlen_reg))
                begin
                    done_next  = 1'b1;
                    found_next = (hits_reg != '0);
                    count_next = hits_reg;
                    tovf_next  = ovf_reg;
                    tlen_next  = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (plen_reg == '0)
                begin
                    hits_next  = hits_reg + 1'b1;
                    state_next = ST_SHIFT;
                end
                else
                begin
                    ci_next    = PAW'(plen_reg - 1'b1);
                    cj_next    = TAW'(k_reg - 1'b1);
                    pat_re     = 1'b1;
                    pat_raddr  = PAW'(plen_reg - 1'b1);
                    txt_re     = 1'b1;
                    txt_raddr  = TAW'(k_reg - 1'b1);
                    state_next = ST_CMP;
                end
            end

            ST_CMP:
            begin
                if (pat_q != txt_q)
                begin
                    state_next = ST_SHIFT;
                end
                else if (ci_reg == '0)
                begin
                    hits_next  = hits_reg + 1'b1;
                    state_next = ST_SHIFT;
                end
                else
                begin
                    ci_next   = ci_reg - 1'b1;
                    cj_next   = cj_reg - 1'b1;
                    pat_re    = 1'b1;
                    pat_raddr = ci_reg - 1'b1;
                    txt_re    = 1'b1;
                    txt_raddr = cj_reg - 1'b1;
                end
            end

            ST_SHIFT:
            begin
                if (k_reg == KW'(tlen_reg))
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_WIN;
                end
                else
                begin
                    txt_re     = 1'b1;
                    txt_raddr  = k_reg[TAW-1:0];
                    state_next = ST_SH_TXT;
                end
            end

            ST_SH_TXT:
            begin
                tbl_req.rd   = 1'b1;
                tbl_req.addr = txt_q;
                state_next   = ST_SH_TBL;
            end

            ST_SH_TBL:
            begin
                k_next     = k_reg + KW'(plen_reg) - KW'(tbl_rdata) + 1'b1;
                state_next = ST_WIN;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg   <= '0;
            closed_reg <= 1'b1;
            tlen_reg   <= '0;
            ovf_reg    <= 1'b0;
            pend_reg   <= 1'b0;
            bcnt_reg   <= '0;
            brdv_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            plen_reg   <= plen_next;
            closed_reg <= closed_next;
            tlen_reg   <= tlen_next;
            ovf_reg    <= ovf_next;
            pend_reg   <= pend_next;
            bcnt_reg   <= bcnt_next;
            brdv_reg   <= brdv_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bidx_reg  <= bidx_next;
        k_reg     <= k_next;
        ci_reg    <= ci_next;
        cj_reg    <= cj_next;
        hits_reg  <= hits_next;
        found_reg <= found_next;
        count_reg <= count_next;
        tovf_reg  <= tovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_mem[pat_waddr] <= data_byte;
        end
        if (pat_re)
        begin
            pat_q <= pat_mem[pat_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (txt_we)
        begin
            txt_mem[txt_waddr] <= data_byte;
        end
        if (txt_re)
        begin
            txt_q <= txt_mem[txt_raddr];
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign found         = found_reg;
    assign match_count   = count_reg;
    assign text_overflow = tovf_reg;

`ifndef ASSERT_OFF
    a_done_after_win: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_WIN && state_reg == ST_IDLE))
        else $error("result strobe without end of search");

    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (found_reg == (count_reg != '0)))
        else $error("found disagrees with match count");

    a_cmp_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (PLW'(ci_reg) < plen_reg))
        else $error("compare index beyond pattern length");

    a_tbl_wr_build: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_req.wr |-> (state_reg == ST_BUILD && !tbl_req.clr))
        else $error("table write outside build sweep");

    a_search_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WIN) |-> closed_reg)
        else $error("search with open pattern");
`endif

endmodule
